// File: hdl/gradient_fill_generator_defines.svh
// Assertion macros shared by the gradient fill checker.
// Needs clk and rst_n in scope where a macro is used.
`ifndef GRADIENT_FILL_GENERATOR_DEFINES_SVH
`define GRADIENT_FILL_GENERATOR_DEFINES_SVH

// Same-cycle implication, off during reset
`define GFG_ASSERT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("gradient fill check failed");

// Next-cycle implication, off during reset
`define GFG_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("gradient fill check failed");

`endif

// File: hdl/gfg_pkg.sv
// Shared types, constants and helpers for the gradient fill generator.
// No dependencies.
package gfg_pkg;

    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = 13;   // width of a dimension register
    localparam int COORD_W = 12;
    localparam int WGT_W   = 25;   // blend weight and divisor, up to 2^24
    localparam int NUM_W   = 32;   // numerator, below 256 * divisor
    localparam int QBITS   = 8;    // quotient bits, one per divider stage
    localparam int NCH     = 4;    // red, green, blue, alpha
    localparam int NCORNER = 4;
    localparam int COLOR_W = 32;

    typedef enum logic [1:0] {
        MODE_VERT   = 2'd0,
        MODE_HORZ   = 2'd1,
        MODE_BILIN  = 2'd2,
        MODE_BILIN3 = 2'd3
    } gfg_mode_t;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_WIDTH  = 3'd1,
        REG_HEIGHT = 3'd2,
        REG_ALPHA  = 3'd3,
        REG_COLOR1 = 3'd4,
        REG_COLOR2 = 3'd5,
        REG_COLOR3 = 3'd6,
        REG_COLOR4 = 3'd7
    } gfg_reg_t;

    // Control that travels with each request
    typedef struct packed {
        logic valid;
        logic in_frame;
    } gfg_ctrl_t;

    // Channel idx of a packed RGBA word, red in the top byte
    function automatic logic [7:0] chan_of(input logic [COLOR_W-1:0] color,
                                           input logic [1:0] idx);
        logic [4:0] lo;
        lo = 5'(5'd24 - {idx, 3'b000});
        return color[lo +: 8];
    endfunction

endpackage

// File: hdl/gfg_front.sv
// Front end: blend weights, weighted channel products and numerator sums.
// Three register stages. Depends on gfg_pkg.
module gfg_front
    import gfg_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req,
    input  logic [COORD_W-1:0]                  column,
    input  logic [COORD_W-1:0]                  row,
    input  logic [1:0]                          mode,
    input  logic [DIM_W-1:0]                    width,
    input  logic [DIM_W-1:0]                    height,
    input  logic [NCORNER-1:0][COLOR_W-1:0]     corner,
    output gfg_ctrl_t                           ctrl_out,
    output logic [NCH-1:0][NUM_W-1:0]           num_out,
    output logic [WGT_W-1:0]                    den_out
);

    logic [DIM_W-1:0]                 w_sat, h_sat, col_ext, row_ext, x_dist, y_dist;
    logic [2*DIM_W-1:0]               p_xy, p_xc, p_ry, p_rc, p_hw;
    logic [NCORNER-1:0][WGT_W-1:0]    wgt_next;
    logic [WGT_W-1:0]                 den_next;
    logic                             in_frame_next;

    gfg_ctrl_t                        s1_ctrl_reg, s2_ctrl_reg, s3_ctrl_reg;
    logic [NCORNER-1:0][WGT_W-1:0]    s1_wgt_reg;
    logic [WGT_W-1:0]                 s1_den_reg, s2_den_reg, s3_den_reg;
    logic [NCH-1:0][NCORNER-1:0][NUM_W-1:0] prod_next, s2_prod_reg;
    logic [NCH-1:0][NUM_W-1:0]        sum_next, s3_num_reg;

    // Stage 1: clamp dimensions, weights and divisor
    always_comb
    begin
        w_sat   = (width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width;
        h_sat   = (height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height;
        col_ext = DIM_W'(column);
        row_ext = DIM_W'(row);
        in_frame_next = (col_ext < w_sat) && (row_ext < h_sat);
        x_dist  = h_sat - row_ext;
        y_dist  = w_sat - col_ext;
        p_xy    = x_dist * y_dist;
        p_xc    = x_dist * col_ext;
        p_ry    = row_ext * y_dist;
        p_rc    = row_ext * col_ext;
        p_hw    = h_sat * w_sat;
        unique case (gfg_mode_t'(mode))
            MODE_VERT:
            begin
                wgt_next[0] = WGT_W'(x_dist);
                wgt_next[1] = WGT_W'(row_ext);
                wgt_next[2] = '0;
                wgt_next[3] = '0;
                den_next    = WGT_W'(h_sat);
            end
            MODE_HORZ:
            begin
                wgt_next[0] = WGT_W'(y_dist);
                wgt_next[1] = WGT_W'(col_ext);
                wgt_next[2] = '0;
                wgt_next[3] = '0;
                den_next    = WGT_W'(w_sat);
            end
            default:
            begin
                wgt_next[0] = p_xy[WGT_W-1:0];
                wgt_next[1] = p_xc[WGT_W-1:0];
                wgt_next[2] = p_ry[WGT_W-1:0];
                wgt_next[3] = p_rc[WGT_W-1:0];
                den_next    = p_hw[WGT_W-1:0];
            end
        endcase
    end

    // Stage 2: channel times weight for every corner
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            for (int k = 0; k < NCORNER; k++)
            begin
                prod_next[c][k] = NUM_W'(chan_of(corner[k], 2'(c))) * NUM_W'(s1_wgt_reg[k]);
            end
        end
    end

    // Stage 3: numerator per channel
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            sum_next[c] = s2_prod_reg[c][0] + s2_prod_reg[c][1]
                        + s2_prod_reg[c][2] + s2_prod_reg[c][3];
        end
    end

    // Valid and in-frame bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
            s3_ctrl_reg <= '0;
        end
        else
        begin
            s1_ctrl_reg <= '{valid: req, in_frame: in_frame_next};
            s2_ctrl_reg <= s1_ctrl_reg;
            s3_ctrl_reg <= s2_ctrl_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        s1_wgt_reg  <= wgt_next;
        s1_den_reg  <= den_next;
        s2_prod_reg <= prod_next;
        s2_den_reg  <= s1_den_reg;
        s3_num_reg  <= sum_next;
        s3_den_reg  <= s2_den_reg;
    end

    assign ctrl_out = s3_ctrl_reg;
    assign num_out  = s3_num_reg;
    assign den_out  = s3_den_reg;

endmodule

// File: hdl/gfg_divider.sv
// Pipelined restoring divider, one quotient bit per stage, four channel lanes.
// Quotient fits QBITS since numerator < 2^QBITS * divisor. Depends on gfg_pkg.
module gfg_divider
    import gfg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  gfg_ctrl_t                     ctrl_in,
    input  logic [NCH-1:0][NUM_W-1:0]     num_in,
    input  logic [WGT_W-1:0]              den_in,
    output gfg_ctrl_t                     ctrl_out,
    output logic [NCH-1:0][QBITS-1:0]     quo_out,
    output logic [NCH-1:0][WGT_W-1:0]     rem_out,
    output logic [WGT_W-1:0]              den_out
);

    gfg_ctrl_t                         ctrl_reg [QBITS];
    logic [WGT_W-1:0]                  den_reg  [QBITS];
    logic [NCH-1:0][NUM_W-1:0]         rem_reg  [QBITS];
    logic [NCH-1:0][QBITS-1:0]         quo_reg  [QBITS];

    for (genvar s = 0; s < QBITS; s++)
    begin : g_stage
        localparam int BIT = QBITS - 1 - s;
        gfg_ctrl_t                 ctrl_prev;
        logic [WGT_W-1:0]          den_prev;
        logic [NCH-1:0][NUM_W-1:0] rem_prev, rem_next;
        logic [NCH-1:0][QBITS-1:0] quo_prev, quo_next;
        logic [NUM_W-1:0]          den_shift;

        if (s == 0)
        begin : g_first
            assign ctrl_prev = ctrl_in;
            assign den_prev  = den_in;
            assign rem_prev  = num_in;
            assign quo_prev  = '0;
        end
        else
        begin : g_rest
            assign ctrl_prev = ctrl_reg[s-1];
            assign den_prev  = den_reg[s-1];
            assign rem_prev  = rem_reg[s-1];
            assign quo_prev  = quo_reg[s-1];
        end

        assign den_shift = NUM_W'(den_prev) << BIT;

        // Trial subtract per lane
        always_comb
        begin
            for (int c = 0; c < NCH; c++)
            begin
                quo_next[c] = quo_prev[c];
                if (rem_prev[c] >= den_shift)
                begin
                    rem_next[c]      = rem_prev[c] - den_shift;
                    quo_next[c][BIT] = 1'b1;
                end
                else
                begin
                    rem_next[c] = rem_prev[c];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctrl_reg[s] <= '0;
            end
            else
            begin
                ctrl_reg[s] <= ctrl_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            den_reg[s] <= den_prev;
            rem_reg[s] <= rem_next;
            quo_reg[s] <= quo_next;
        end
    end

    // Remainder is below the divisor after the last stage
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            rem_out[c] = rem_reg[QBITS-1][c][WGT_W-1:0];
        end
    end

    assign ctrl_out = ctrl_reg[QBITS-1];
    assign quo_out  = quo_reg[QBITS-1];
    assign den_out  = den_reg[QBITS-1];

endmodule

// File: hdl/gradient_fill_generator.sv
// Gradient fill generator: one pixel coordinate in, one RGBA colour out.
// Config registers are written through cfg_valid/cfg_ready, cfg_index, cfg_data.
// Depends on gfg_pkg, gfg_front and gfg_divider.
//
// Usage:
//   Raise start with column and row; busy stays low, so a request is taken
//   every cycle and one pixel per clock is sustained.
//   Each request yields one result, flagged by result_valid for one cycle,
//   after passing three front stages (weights, products, sums), eight
//   divider stages (one quotient bit each) and one rounding stage.
//   Results come out in request order. The receiver cannot hold them off.
//   Pixels outside the image give in_image low and zero channels.
//   cfg_ready is always high; write registers only with no request in flight.
//   Reset clears the pipeline valid bits and loads mode 0, width 1,
//   height 1, no alpha and black colours.
module gradient_fill_generator
    import gfg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [COORD_W-1:0] column,
    input  logic [COORD_W-1:0] row,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               result_valid,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    output logic [7:0]         alpha,
    output logic               alpha_present,
    output logic               in_image
);

    logic [1:0]                    mode_reg;
    logic [DIM_W-1:0]              width_reg, height_reg;
    logic                          has_alpha_reg;
    logic [NCORNER-1:0][COLOR_W-1:0] color_reg;

    gfg_ctrl_t                     front_ctrl, div_ctrl;
    logic [NCH-1:0][NUM_W-1:0]     front_num;
    logic [WGT_W-1:0]              front_den, div_den;
    logic [NCH-1:0][QBITS-1:0]     div_quo;
    logic [NCH-1:0][WGT_W-1:0]     div_rem;
    logic [NCH-1:0][7:0]           chan_next;
    logic [WGT_W:0]                rem_twice;
    logic                          round_up;

    logic                          valid_reg, inside_reg, alpha_present_reg;
    logic [NCH-1:0][7:0]           chan_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_VERT;
            width_reg     <= DIM_W'(1);
            height_reg    <= DIM_W'(1);
            has_alpha_reg <= 1'b0;
            color_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (gfg_reg_t'(cfg_index))
                REG_MODE:   mode_reg      <= cfg_data[1:0];
                REG_WIDTH:  width_reg     <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_reg    <= cfg_data[DIM_W-1:0];
                REG_ALPHA:  has_alpha_reg <= cfg_data[0];
                REG_COLOR1: color_reg[0]  <= cfg_data;
                REG_COLOR2: color_reg[1]  <= cfg_data;
                REG_COLOR3: color_reg[2]  <= cfg_data;
                REG_COLOR4: color_reg[3]  <= cfg_data;
                default:    mode_reg      <= mode_reg;
            endcase
        end
    end

    gfg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (start && !busy),
        .column   (column),
        .row      (row),
        .mode     (mode_reg),
        .width    (width_reg),
        .height   (height_reg),
        .corner   (color_reg),
        .ctrl_out (front_ctrl),
        .num_out  (front_num),
        .den_out  (front_den)
    );

    gfg_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (front_ctrl),
        .num_in   (front_num),
        .den_in   (front_den),
        .ctrl_out (div_ctrl),
        .quo_out  (div_quo),
        .rem_out  (div_rem),
        .den_out  (div_den)
    );

    // Rounding (horizontal mode only: nearest, ties to even; other modes truncate) and masking
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            rem_twice = {div_rem[c], 1'b0};
            round_up  = (rem_twice > (WGT_W+1)'(div_den))
                     || ((rem_twice == (WGT_W+1)'(div_den)) && div_quo[c][0]);
            if (gfg_mode_t'(mode_reg) == MODE_HORZ && round_up && (div_quo[c] != 8'hff))
            begin
                chan_next[c] = div_quo[c] + 8'd1;
            end
            else
            begin
                chan_next[c] = div_quo[c];
            end
            if (!div_ctrl.in_frame)
            begin
                chan_next[c] = '0;
            end
        end
        if (!has_alpha_reg)
        begin
            chan_next[3] = '0;
        end
    end

    // Output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= div_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        chan_reg          <= chan_next;
        inside_reg        <= div_ctrl.in_frame;
        alpha_present_reg <= has_alpha_reg;
    end

    assign result_valid  = valid_reg;
    assign red           = chan_reg[0];
    assign green         = chan_reg[1];
    assign blue          = chan_reg[2];
    assign alpha         = chan_reg[3];
    assign alpha_present = alpha_present_reg;
    assign in_image      = inside_reg;

endmodule

// File: hdl/gfg_checker.sv
// Port-level checks for the gradient fill generator, bound to the top level.
// Depends on gradient_fill_generator_defines.svh.
`include "gradient_fill_generator_defines.svh"

module gfg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_valid,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic [7:0] alpha,
    input logic       alpha_present,
    input logic       in_image
);

    // Outside pixels are black
    `GFG_ASSERT(a_outside_zero, result_valid && !in_image, {red, green, blue, alpha} == 32'd0)
    // Three-channel pixels carry no alpha
    `GFG_ASSERT(a_no_alpha, result_valid && !alpha_present, alpha == 8'd0)
    // Fixed latency from request to result
    `GFG_ASSERT(a_latency, start && !busy, ##12 result_valid)
    // No result without an earlier accepted request
    `GFG_ASSERT(a_no_spurious, result_valid, $past(start && !busy, 12))
    // Never busy in the cycle after a request is raised
    `GFG_ASSERT_NEXT(a_accept, start, !busy)

endmodule

bind gradient_fill_generator gfg_checker u_gfg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_valid  (result_valid),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha         (alpha),
    .alpha_present (alpha_present),
    .in_image      (in_image)
);
